### rtl/sac_nru_pkg.sv
// Shared types and constants for the set-associative NRU cache lookup.
// Holds geometry limits, configuration register indexes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sac_nru_pkg;

  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_WIDTH = 32;

  localparam int SET_W   = $clog2(MAX_SETS);
  localparam int WAY_W   = $clog2(MAX_WAYS);
  localparam int LINES   = MAX_SETS * MAX_WAYS;
  localparam int LINE_W  = SET_W + WAY_W;
  localparam int TAG_W   = 32;
  localparam int CNT_W   = 32;

  // Configuration register widths
  localparam int ABITS_W = 6;
  localparam int OBITS_W = 5;
  localparam int IBITS_W = 4;
  localparam int NWAYS_W = 4;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE  = 2'd3;

  // Configuration reset values
  localparam logic [ABITS_W-1:0] RST_ADDRESS_BITS = 6'd32;
  localparam logic [OBITS_W-1:0] RST_OFFSET_BITS  = 5'd2;
  localparam logic [IBITS_W-1:0] RST_INDEX_BITS   = 4'd3;
  localparam logic [NWAYS_W-1:0] RST_WAYS_IN_USE  = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOOKUP,
    ST_UPDATE
  } seq_state_t;

endpackage

`default_nettype wire

### rtl/set_assoc_cache_nru_lookup.sv
// Set-associative cache lookup with NRU replacement: one address in, one result out per item.
// A small sequencer walks the ways of the selected set through one tag compare unit.
// Depends on sac_nru_pkg.
//
// Usage: each accepted address yields exactly one result (hit, way, set, saturating miss count).
// An item runs decode, k way compares and update before the next one can be taken, where k is
// the number of ways compared: the hit way plus one on a hit, ways_in_use on a miss. The tag
// RAM has one read port and the single comparator checks one way per cycle; this loop sets the
// rate. in_ready is low while an item is in progress. A finished result waits in the output
// register, and the next address is accepted meanwhile. Reset takes effect at once: a per-set
// flag marks rows never written, which read as invalid with all NRU marks set, so there is no
// clearing pass. Users must write configuration only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_nru_lookup (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [sac_nru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sac_nru_pkg::CFG_W-1:0]     cfg_wdata,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [sac_nru_pkg::ADDR_WIDTH-1:0] in_address,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_hit,
  output logic [sac_nru_pkg::WAY_W-1:0]          out_way,
  output logic [sac_nru_pkg::SET_W-1:0]          out_set_index,
  output logic [sac_nru_pkg::CNT_W-1:0]          out_miss_total
);

  localparam int MW = sac_nru_pkg::MAX_WAYS;
  localparam int SW = sac_nru_pkg::SET_W;
  localparam int WW = sac_nru_pkg::WAY_W;
  localparam int AW = sac_nru_pkg::ADDR_WIDTH;
  localparam int TW = sac_nru_pkg::TAG_W;
  localparam int CW = sac_nru_pkg::CNT_W;

  // configuration registers
  logic [sac_nru_pkg::ABITS_W-1:0] address_bits_r;
  logic [sac_nru_pkg::OBITS_W-1:0] offset_bits_r;
  logic [sac_nru_pkg::IBITS_W-1:0] index_bits_r;
  logic [sac_nru_pkg::NWAYS_W-1:0] ways_in_use_r;

  // sequencer and item registers
  sac_nru_pkg::seq_state_t state_r, state_nxt;
  logic [AW-1:0] addr_r;
  logic [SW-1:0] set_r, set_nxt;
  logic [TW-1:0] tag_r, tag_nxt;
  logic [WW-1:0] way_r, way_nxt;
  logic          hit_r, hit_nxt;
  logic [CW-1:0] miss_cnt_r, miss_cnt_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r;
  logic [WW-1:0] out_way_r;
  logic [SW-1:0] out_set_r;
  logic [CW-1:0] out_miss_r;
  logic          out_load;

  // memories: tags per line, {nru, valid} per set row
  logic [TW-1:0]   tag_mem [sac_nru_pkg::LINES];
  logic [2*MW-1:0] meta_mem [sac_nru_pkg::MAX_SETS];
  logic [sac_nru_pkg::MAX_SETS-1:0] row_init_r;

  logic [TW-1:0]   tag_rd_r;
  logic [2*MW-1:0] meta_rd_r;
  logic            row_ok_r;

  logic [sac_nru_pkg::LINE_W-1:0] tag_raddr;
  logic [sac_nru_pkg::LINE_W-1:0] tag_waddr;
  logic                           tag_we;
  logic                           meta_re;
  logic                           meta_we;
  logic [2*MW-1:0]                meta_wdata;

  // address decode
  logic [5:0]    abits_c;
  logic [AW-1:0] amask_c;
  logic [AW-1:0] am_c;
  logic [3:0]    ibits_c;
  logic [SW:0]   imask_c;
  logic [AW-1:0] shifted_c;
  logic [SW-1:0] set_c;
  logic [5:0]    tsh_c;
  logic [TW-1:0] tag_c;

  // way control
  logic [sac_nru_pkg::NWAYS_W-1:0] nways_c;
  logic [WW-1:0] last_way_c;
  logic [MW-1:0] inuse_c;
  logic [MW-1:0] valid_eff;
  logic [MW-1:0] nru_eff;
  logic          hit_now;
  logic          vic_found;
  logic [WW-1:0] victim;
  logic [MW-1:0] valid_new;
  logic [MW-1:0] nru_new;
  logic [WW-1:0] fill_way;

  assign abits_c   = (address_bits_r > 6'(AW)) ? 6'(AW) : address_bits_r;
  assign amask_c   = (abits_c >= 6'(AW)) ? '1 : ((AW'(1) << abits_c) - AW'(1));
  assign am_c      = addr_r & amask_c;
  assign ibits_c   = (index_bits_r > 4'(SW)) ? 4'(SW) : index_bits_r;
  assign imask_c   = ((SW+1)'(1) << ibits_c) - (SW+1)'(1);
  assign shifted_c = am_c >> offset_bits_r;
  assign set_c     = shifted_c[SW-1:0] & imask_c[SW-1:0];
  assign tsh_c     = {1'b0, offset_bits_r} + {2'b00, ibits_c};
  assign tag_c     = TW'(am_c >> tsh_c);

  assign nways_c = (ways_in_use_r == '0) ? sac_nru_pkg::NWAYS_W'(1) :
                   (ways_in_use_r > sac_nru_pkg::NWAYS_W'(MW)) ?
                   sac_nru_pkg::NWAYS_W'(MW) : ways_in_use_r;
  assign last_way_c = WW'(nways_c - sac_nru_pkg::NWAYS_W'(1));

  always_comb begin
    for (int w = 0; w < MW; w++) begin
      inuse_c[w] = (w < int'(nways_c));
    end
  end

  // rows never written read as all invalid with every mark set
  assign valid_eff = row_ok_r ? meta_rd_r[MW-1:0] : '0;
  assign nru_eff   = row_ok_r ? meta_rd_r[2*MW-1:MW] : '1;
  assign hit_now   = valid_eff[way_r] && (tag_rd_r == tag_r);

  // lowest in-use way with its mark set
  always_comb begin
    vic_found = |(nru_eff & inuse_c);
    victim    = '0;
    for (int w = MW - 1; w >= 0; w--) begin
      if (nru_eff[w] && inuse_c[w]) begin
        victim = WW'(w);
      end
    end
  end

  always_comb begin
    valid_new = valid_eff;
    nru_new   = nru_eff;
    fill_way  = way_r;
    if (!hit_r) begin
      if (vic_found) begin
        fill_way = victim;
      end else begin
        nru_new  = nru_eff | inuse_c;
        fill_way = '0;
      end
      valid_new[fill_way] = 1'b1;
    end
    nru_new[fill_way] = 1'b0;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_bits_r <= sac_nru_pkg::RST_ADDRESS_BITS;
      offset_bits_r  <= sac_nru_pkg::RST_OFFSET_BITS;
      index_bits_r   <= sac_nru_pkg::RST_INDEX_BITS;
      ways_in_use_r  <= sac_nru_pkg::RST_WAYS_IN_USE;
    end else if (cfg_we) begin
      case (cfg_index)
        sac_nru_pkg::CFG_ADDRESS_BITS: address_bits_r <= cfg_wdata;
        sac_nru_pkg::CFG_OFFSET_BITS:  offset_bits_r  <= cfg_wdata[sac_nru_pkg::OBITS_W-1:0];
        sac_nru_pkg::CFG_INDEX_BITS:   index_bits_r   <= cfg_wdata[sac_nru_pkg::IBITS_W-1:0];
        sac_nru_pkg::CFG_WAYS_IN_USE:  ways_in_use_r  <= cfg_wdata[sac_nru_pkg::NWAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: next state and memory controls
  always_comb begin
    state_nxt     = state_r;
    set_nxt       = set_r;
    tag_nxt       = tag_r;
    way_nxt       = way_r;
    hit_nxt       = hit_r;
    miss_cnt_nxt  = miss_cnt_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    tag_raddr     = {set_r, way_r};
    tag_we        = 1'b0;
    tag_waddr     = {set_r, fill_way};
    meta_re       = 1'b0;
    meta_we       = 1'b0;
    meta_wdata    = {nru_new, valid_new};
    in_ready      = (state_r == sac_nru_pkg::ST_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sac_nru_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sac_nru_pkg::ST_DECODE;
        end
      end
      sac_nru_pkg::ST_DECODE: begin
        set_nxt   = set_c;
        tag_nxt   = tag_c;
        way_nxt   = '0;
        hit_nxt   = 1'b0;
        tag_raddr = {set_c, {WW{1'b0}}};
        meta_re   = 1'b1;
        state_nxt = sac_nru_pkg::ST_LOOKUP;
      end
      sac_nru_pkg::ST_LOOKUP: begin
        // fetch the next way while comparing this one
        tag_raddr = {set_r, WW'(way_r + WW'(1))};
        if (hit_now) begin
          hit_nxt   = 1'b1;
          state_nxt = sac_nru_pkg::ST_UPDATE;
        end else if (way_r == last_way_c) begin
          state_nxt = sac_nru_pkg::ST_UPDATE;
        end else begin
          way_nxt = WW'(way_r + WW'(1));
        end
      end
      sac_nru_pkg::ST_UPDATE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          meta_we  = 1'b1;
          tag_we   = !hit_r;
          out_load = 1'b1;
          out_valid_nxt = 1'b1;
          if (!hit_r && (miss_cnt_r != '1)) begin
            miss_cnt_nxt = miss_cnt_r + CW'(1);
          end
          state_nxt = sac_nru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sac_nru_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sac_nru_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      miss_cnt_r  <= '0;
      row_init_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      if (meta_we) begin
        row_init_r[set_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      addr_r <= in_address;
    end
    set_r <= set_nxt;
    tag_r <= tag_nxt;
    way_r <= way_nxt;
    hit_r <= hit_nxt;
    if (out_load) begin
      out_hit_r  <= hit_r;
      out_way_r  <= fill_way;
      out_set_r  <= set_r;
      out_miss_r <= miss_cnt_nxt;
    end
  end

  // tag RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_r;
    end
    tag_rd_r <= tag_mem[tag_raddr];
  end

  // valid and NRU rows: read in decode, written back in update
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[set_r] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rd_r <= meta_mem[set_c];
      row_ok_r  <= row_init_r[set_c];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_way        = out_way_r;
  assign out_set_index  = out_set_r;
  assign out_miss_total = out_miss_r;

endmodule

`default_nettype wire

### rtl/sac_nru_checker.sv
// Port-level checks for the set-associative NRU cache lookup, bound to its top level.
// Depends on sac_nru_pkg and set_assoc_cache_nru_lookup.
`timescale 1ns / 1ps
`default_nettype none

module sac_nru_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic                                out_hit,
  input wire logic [sac_nru_pkg::WAY_W-1:0]       out_way,
  input wire logic [sac_nru_pkg::SET_W-1:0]       out_set_index,
  input wire logic [sac_nru_pkg::CNT_W-1:0]       out_miss_total
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_way) &&
    $stable(out_set_index) && $stable(out_miss_total))
    else $error("stalled result changed");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");

  // a miss always counts
  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_miss_total != '0)
    else $error("miss reported with zero miss count");

endmodule

bind set_assoc_cache_nru_lookup sac_nru_checker u_sac_nru_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hit        (out_hit),
  .out_way        (out_way),
  .out_set_index  (out_set_index),
  .out_miss_total (out_miss_total)
);

`default_nettype wire

### tb/tb_set_assoc_cache_nru_lookup.sv
// Self-checking testbench for set_assoc_cache_nru_lookup: directed and random address items,
// predicted by a behavioral NRU cache model kept here, with random idling on both channels.
// Depends on sac_nru_pkg and the set_assoc_cache_nru_lookup RTL.
`timescale 1ns / 1ps

module tb_set_assoc_cache_nru_lookup;

  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int POOL_MAX     = sac_nru_pkg::MAX_WAYS + 2;

  typedef struct {
    logic                          hit;
    logic [sac_nru_pkg::WAY_W-1:0] way;
    logic [sac_nru_pkg::SET_W-1:0] set_index;
    logic [sac_nru_pkg::CNT_W-1:0] miss_total;
  } lookup_result_t;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [sac_nru_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sac_nru_pkg::CFG_W-1:0]      cfg_wdata;
  logic                               in_valid;
  logic                               in_ready;
  logic [sac_nru_pkg::ADDR_WIDTH-1:0] in_address;
  logic                               out_valid;
  logic                               out_ready;
  logic                               out_hit;
  logic [sac_nru_pkg::WAY_W-1:0]      out_way;
  logic [sac_nru_pkg::SET_W-1:0]      out_set_index;
  logic [sac_nru_pkg::CNT_W-1:0]      out_miss_total;

  set_assoc_cache_nru_lookup DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_way        (out_way),
    .out_set_index  (out_set_index),
    .out_miss_total (out_miss_total)
  );

  // Cache image and geometry as the block should hold them
  logic [sac_nru_pkg::TAG_W-1:0]   tag_mem [sac_nru_pkg::LINES];
  bit                              valid_mem [sac_nru_pkg::LINES] = '{default: 1'b0};
  bit                              nru_mem [sac_nru_pkg::LINES] = '{default: 1'b1};
  logic [sac_nru_pkg::CNT_W-1:0]   miss_count = '0;
  logic [sac_nru_pkg::ABITS_W-1:0] geo_abits = sac_nru_pkg::RST_ADDRESS_BITS;
  logic [sac_nru_pkg::OBITS_W-1:0] geo_obits = sac_nru_pkg::RST_OFFSET_BITS;
  logic [sac_nru_pkg::IBITS_W-1:0] geo_ibits = sac_nru_pkg::RST_INDEX_BITS;
  logic [sac_nru_pkg::NWAYS_W-1:0] geo_ways  = sac_nru_pkg::RST_WAYS_IN_USE;

  lookup_result_t lookup_q[$];
  int  fail_count = 0;
  bit  source_quiet = 1'b0;
  bit  sink_quiet = 1'b0;
  int  hold_off_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_addr_bits();
    return (geo_abits > sac_nru_pkg::ADDR_WIDTH) ? sac_nru_pkg::ADDR_WIDTH : int'(geo_abits);
  endfunction

  function automatic int eff_index_bits();
    return (geo_ibits > sac_nru_pkg::SET_W) ? sac_nru_pkg::SET_W : int'(geo_ibits);
  endfunction

  function automatic int eff_ways();
    if (geo_ways == 0) return 1;
    return (geo_ways > sac_nru_pkg::MAX_WAYS) ? sac_nru_pkg::MAX_WAYS : int'(geo_ways);
  endfunction

  // Look the address up in the cache image, update it and queue the result
  function automatic void predict_lookup(input logic [sac_nru_pkg::ADDR_WIDTH-1:0] addr);
    logic [63:0]                   a;
    logic [sac_nru_pkg::TAG_W-1:0] tag;
    int             ib, nways, set, base, way;
    bit             hit, found;
    lookup_result_t r;
    ib    = eff_index_bits();
    nways = eff_ways();
    a     = 64'(addr) & ((64'd1 << eff_addr_bits()) - 64'd1);
    set   = int'((a >> geo_obits) & ((64'd1 << ib) - 64'd1)) % sac_nru_pkg::MAX_SETS;
    tag   = sac_nru_pkg::TAG_W'(a >> (int'(geo_obits) + ib));
    base  = set * sac_nru_pkg::MAX_WAYS;
    hit   = 1'b0;
    found = 1'b0;
    way   = 0;
    for (int w = 0; w < nways; w++) begin
      if (!hit && valid_mem[base + w] && tag_mem[base + w] == tag) begin
        hit = 1'b1;
        way = w;
        nru_mem[base + w] = 1'b0;
      end
    end
    if (!hit) begin
      for (int w = 0; w < nways; w++) begin
        if (!found && nru_mem[base + w]) begin
          found = 1'b1;
          way = w;
        end
      end
      // no candidate left: re-arm the mark of every in-use way in the set and take way 0
      if (!found) begin
        for (int w = 0; w < nways; w++) nru_mem[base + w] = 1'b1;
        way = 0;
      end
      tag_mem[base + way]   = tag;
      valid_mem[base + way] = 1'b1;
      nru_mem[base + way]   = 1'b0;
      if (miss_count != '1) miss_count++;
    end
    r.hit        = hit;
    r.way        = sac_nru_pkg::WAY_W'(way);
    r.set_index  = sac_nru_pkg::SET_W'(set);
    r.miss_total = miss_count;
    lookup_q.insert(lookup_q.size(), r);
  endfunction

  // Called at a rising edge; returns at the edge that accepts the item
  task automatic send_address(input logic [sac_nru_pkg::ADDR_WIDTH-1:0] addr);
    int gap;
    gap = source_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
    predict_lookup(addr);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk);
    // let the last write-back finish before touching the registers
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [sac_nru_pkg::CFG_W-1:0] abits,
                              input logic [sac_nru_pkg::CFG_W-1:0] obits,
                              input logic [sac_nru_pkg::CFG_W-1:0] ibits,
                              input logic [sac_nru_pkg::CFG_W-1:0] ways);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= sac_nru_pkg::CFG_ADDRESS_BITS;
    cfg_wdata <= abits;
    @(posedge clk);
    cfg_index <= sac_nru_pkg::CFG_OFFSET_BITS;
    cfg_wdata <= obits;
    @(posedge clk);
    cfg_index <= sac_nru_pkg::CFG_INDEX_BITS;
    cfg_wdata <= ibits;
    @(posedge clk);
    cfg_index <= sac_nru_pkg::CFG_WAYS_IN_USE;
    cfg_wdata <= ways;
    @(posedge clk);
    cfg_we    <= 1'b0;
    geo_abits = abits[sac_nru_pkg::ABITS_W-1:0];
    geo_obits = obits[sac_nru_pkg::OBITS_W-1:0];
    geo_ibits = ibits[sac_nru_pkg::IBITS_W-1:0];
    geo_ways  = ways[sac_nru_pkg::NWAYS_W-1:0];
  endtask

  // Reset geometry: 32 address bits, 4-byte blocks, 8 sets, direct mapped
  task automatic test_reset_geometry();
    send_address(32'h0000_0000);
    send_address(32'h0000_0003);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_FFFC);
    send_address(32'h0000_0020);
    send_address(32'h0000_0000);
  endtask

  // Fill one set, hit, then force the all-marks-clear case
  task automatic test_nru_replacement();
    set_geometry(6'd32, 6'd4, 6'd2, 6'd4);
    for (int t = 1; t <= 4; t++) begin
      send_address(sac_nru_pkg::ADDR_WIDTH'((t << 6) | (1 << 4)));
    end
    send_address(sac_nru_pkg::ADDR_WIDTH'((3 << 6) | (1 << 4)));
    send_address(sac_nru_pkg::ADDR_WIDTH'((5 << 6) | (1 << 4)));
    send_address(sac_nru_pkg::ADDR_WIDTH'((6 << 6) | (1 << 4)));
    send_address(sac_nru_pkg::ADDR_WIDTH'((4 << 6) | (1 << 4)));
  endtask

  // Zero and oversized address width, fields past the address, clamped index and ways
  task automatic test_geometry_extremes();
    set_geometry(6'd0, 6'd2, 6'd3, 6'd1);
    send_address(32'hFFFF_FFFF);
    send_address(32'hA5A5_A5A5);
    // upper data bits above the offset, index and ways register widths must drop
    set_geometry(6'd63, 6'h3F, 6'h3F, 6'h30);
    send_address(32'h8000_0000);
    send_address(32'h7FFF_FFFF);
    set_geometry(6'd1, 6'd0, 6'd8, 6'd15);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_FFFE);
    set_geometry(6'd32, 6'd0, 6'd8, 6'd8);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0000);
  endtask

  // Hold the result side off so the block fills and drops in_ready
  task automatic test_output_stall();
    logic [sac_nru_pkg::ADDR_WIDTH-1:0] addr;
    set_geometry(6'd32, 6'd2, 6'd3, 6'd8);
    source_quiet    = 1'b1;
    sink_quiet      = 1'b1;
    hold_off_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      addr = sac_nru_pkg::ADDR_WIDTH'({$urandom_range(0, 11), 5'd0} | ($urandom & 32'h1F));
      send_address(addr);
    end
    source_quiet = 1'b0;
    sink_quiet   = 1'b0;
  endtask

  // Fixed then random geometry phases; most items reuse a few tags in a few sets to get hits
  task automatic test_random_traffic();
    logic [sac_nru_pkg::TAG_W-1:0] tag_pool [POOL_MAX];
    int               set_pool [4];
    logic [63:0]      keep, field;
    int               ab, ib, ob, npool;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) begin
        set_geometry(6'd32, 6'd0, 6'd8, 6'd8);
      end else if (phase == 1) begin
        set_geometry(6'd1, 6'd0, 6'd0, 6'd1);
      end else if ($urandom_range(0, 3) == 0) begin
        set_geometry(sac_nru_pkg::CFG_W'($urandom_range(0, 63)),
                     sac_nru_pkg::CFG_W'($urandom_range(0, 63)),
                     sac_nru_pkg::CFG_W'($urandom_range(0, 63)),
                     sac_nru_pkg::CFG_W'($urandom_range(0, 63)));
      end else begin
        set_geometry(sac_nru_pkg::CFG_W'($urandom_range(8, 32)),
                     sac_nru_pkg::CFG_W'($urandom_range(0, 6)),
                     sac_nru_pkg::CFG_W'($urandom_range(0, 8)),
                     sac_nru_pkg::CFG_W'($urandom_range(1, 8)));
      end
      source_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet   = ($urandom_range(0, 3) == 0);
      ab    = eff_addr_bits();
      ib    = eff_index_bits();
      ob    = geo_obits;
      npool = eff_ways() + 2;
      keep  = (64'd1 << ab) - 64'd1;
      foreach (tag_pool[i]) tag_pool[i] = $urandom;
      foreach (set_pool[i]) set_pool[i] = int'($urandom & ((32'd1 << ib) - 32'd1));
      for (int i = 0; i < 134; i++) begin
        if ($urandom_range(0, 99) < 15) begin
          send_address($urandom);
        end else begin
          field = (64'(tag_pool[$urandom_range(0, npool - 1)]) << (ob + ib))
                | (64'(set_pool[$urandom_range(0, 3)]) << ob)
                | (64'($urandom) & ((64'd1 << ob) - 64'd1));
          send_address(sac_nru_pkg::ADDR_WIDTH'((field & keep) | (64'($urandom) & ~keep)));
        end
      end
    end
    source_quiet = 1'b0;
    sink_quiet   = 1'b0;
  endtask

  // Result side: random stall per item, then compare with the oldest prediction
  initial begin : result_checker
    int             stall;
    lookup_result_t want;
    out_ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else begin
        stall = sink_quiet ? 0 : $urandom_range(0, 15);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (lookup_q.size() == 0) begin
        $error("result item with no prediction pending");
        fail_count++;
      end else begin
        want = lookup_q.pop_front();
        if (out_hit !== want.hit) begin
          $error("out_hit expected %0d got %0d", want.hit, out_hit);
          fail_count++;
        end
        if (out_way !== want.way) begin
          $error("out_way expected %0d got %0d", want.way, out_way);
          fail_count++;
        end
        if (out_set_index !== want.set_index) begin
          $error("out_set_index expected %0d got %0d", want.set_index, out_set_index);
          fail_count++;
        end
        if (out_miss_total !== want.miss_total) begin
          $error("out_miss_total expected %0d got %0d", want.miss_total, out_miss_total);
          fail_count++;
        end
      end
    end
  end

  // End the run when neither channel has moved for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= sac_nru_pkg::CFG_ADDRESS_BITS;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_address <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_nru_replacement();
    test_geometry_extremes();
    test_output_stall();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
